[sv/lxr_pkg.sv]
// Shared types, constants and helper functions for the expression token lexer.
// Used by lxr_front, lxr_queue, lxr_back and expression_token_lexer; depends on nothing.
`default_nettype none
package lxr_pkg;

  localparam int MAX_INPUT_LEN = 4096;
  localparam int VALUE_WIDTH   = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam int POS_MAX_INT = (MAX_INPUT_LEN - 1 < 4095) ? MAX_INPUT_LEN - 1 : 4095;
  localparam logic [11:0] POS_MAX = 12'(POS_MAX_INT);
  localparam logic [31:0] VAL_MAX = (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << VALUE_WIDTH) - 64'd1);
  localparam logic [11:0] COUNT_MAX = 12'hFFF;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DIE   = 8'h64;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_DICE,
    MODE_ID,
    MODE_INT,
    MODE_FRAC
  } lex_mode_t;

  typedef enum logic [2:0] {
    KIND_CHAR = 3'd0,
    KIND_INT  = 3'd1,
    KIND_DEC  = 3'd2,
    KIND_ID   = 3'd3,
    KIND_EOI  = 3'd4,
    KIND_ERR  = 3'd5
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  ch;
    logic [11:0] start;
    logic [11:0] len;
    logic [31:0] whole;
    logic [31:0] frac;
    logic [11:0] digits;
    logic        sat;
  } token_t;

  // One queue entry holds every token a single byte produced.
  typedef struct packed {
    logic   has_a;
    token_t tok_a;
    logic   has_b;
    token_t tok_b;
  } entry_t;

  // Returns {saturated, acc * 10 + d clamped to VAL_MAX}.
  function automatic logic [32:0] acc_digit(input logic [31:0] acc, input logic [3:0] d);
    logic [35:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, d};
    if (v > {4'b0, VAL_MAX}) begin
      return {1'b1, VAL_MAX};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage
`default_nettype wire

[sv/lxr_front.sv]
// Front end of the lexer: accepts bytes, runs the mode machine and builds token entries.
// Depends on lxr_pkg.
`default_nettype none
module lxr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      char_in,
  input  wire logic            queue_full,
  output logic                 push,
  output lxr_pkg::entry_t      push_entry
);

  lxr_pkg::lex_mode_t mode, mode_next;
  logic [11:0] pos, pos_next;
  logic [11:0] tstart, tstart_next;
  logic [31:0] whole, whole_next;
  logic [31:0] frac, frac_next;
  logic [11:0] fcount, fcount_next;
  logic        sat, sat_next;
  logic        accept;
  logic        pend;
  logic        is_dig, is_let, is_op, is_blank;
  logic [11:0] len;
  logic [3:0]  dval;
  logic [32:0] acc_w, acc_f;
  lxr_pkg::entry_t ent;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_dig   = (char_in >= lxr_pkg::CH_ZERO) && (char_in <= lxr_pkg::CH_NINE);
  assign is_let   = (char_in >= 8'h61 && char_in <= 8'h7A) || (char_in >= 8'h41 && char_in <= 8'h5A);
  assign is_op    = (char_in == lxr_pkg::CH_PLUS) || (char_in == lxr_pkg::CH_MINUS) ||
                    (char_in == lxr_pkg::CH_SLASH) || (char_in == lxr_pkg::CH_STAR) ||
                    (char_in == lxr_pkg::CH_CARET) || (char_in == lxr_pkg::CH_COMMA) ||
                    (char_in == lxr_pkg::CH_LPAR) || (char_in == lxr_pkg::CH_RPAR);
  assign is_blank = (char_in == lxr_pkg::CH_SPACE) ||
                    (char_in >= lxr_pkg::CH_TAB && char_in <= lxr_pkg::CH_CR);
  assign len      = pos - tstart;
  assign dval     = 4'(char_in - lxr_pkg::CH_ZERO);
  assign acc_w    = lxr_pkg::acc_digit(whole, dval);
  assign acc_f    = lxr_pkg::acc_digit(frac, dval);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= lxr_pkg::MODE_START;
      pos    <= '0;
      tstart <= '0;
      whole  <= '0;
      frac   <= '0;
      fcount <= '0;
      sat    <= 1'b0;
    end else if (accept) begin
      mode   <= mode_next;
      pos    <= pos_next;
      tstart <= tstart_next;
      whole  <= whole_next;
      frac   <= frac_next;
      fcount <= fcount_next;
      sat    <= sat_next;
    end
  end

  always_comb begin
    mode_next   = mode;
    tstart_next = tstart;
    whole_next  = whole;
    frac_next   = frac;
    fcount_next = fcount;
    sat_next    = sat;
    pend        = 1'b1;
    ent         = '0;
    ent.tok_a.start = tstart;
    ent.tok_a.len   = len;
    ent.tok_b.start = pos;

    case (mode)
      lxr_pkg::MODE_DICE: begin
        if (is_let) begin
          mode_next = lxr_pkg::MODE_ID;
          pend      = 1'b0;
        end else begin
          ent.has_a      = 1'b1;
          ent.tok_a.kind = lxr_pkg::KIND_CHAR;
          ent.tok_a.ch   = lxr_pkg::CH_DIE;
          mode_next      = lxr_pkg::MODE_START;
        end
      end
      lxr_pkg::MODE_ID: begin
        if (is_let || is_dig) begin
          pend = 1'b0;
        end else begin
          ent.has_a      = 1'b1;
          ent.tok_a.kind = lxr_pkg::KIND_ID;
          mode_next      = lxr_pkg::MODE_START;
        end
      end
      lxr_pkg::MODE_INT: begin
        if (char_in == lxr_pkg::CH_POINT) begin
          mode_next = lxr_pkg::MODE_FRAC;
          pend      = 1'b0;
        end else if (is_dig) begin
          whole_next = acc_w[31:0];
          sat_next   = sat | acc_w[32];
          pend       = 1'b0;
        end else begin
          ent.has_a       = 1'b1;
          ent.tok_a.kind  = lxr_pkg::KIND_INT;
          ent.tok_a.whole = whole;
          ent.tok_a.sat   = sat;
          mode_next       = lxr_pkg::MODE_START;
        end
      end
      lxr_pkg::MODE_FRAC: begin
        if (is_dig) begin
          frac_next   = acc_f[31:0];
          fcount_next = (fcount < lxr_pkg::COUNT_MAX) ? fcount + 12'd1 : fcount;
          sat_next    = sat | acc_f[32] | (fcount == lxr_pkg::COUNT_MAX);
          pend        = 1'b0;
        end else begin
          ent.has_a        = 1'b1;
          ent.tok_a.kind   = lxr_pkg::KIND_DEC;
          ent.tok_a.whole  = whole;
          ent.tok_a.frac   = frac;
          ent.tok_a.digits = fcount;
          ent.tok_a.sat    = sat;
          mode_next        = lxr_pkg::MODE_START;
        end
      end
      default: begin
        mode_next = lxr_pkg::MODE_START;
      end
    endcase

    if (pend) begin
      if (is_op) begin
        ent.has_b      = 1'b1;
        ent.tok_b.kind = lxr_pkg::KIND_CHAR;
        ent.tok_b.ch   = char_in;
        ent.tok_b.len  = 12'd1;
      end else if (char_in == lxr_pkg::CH_DIE) begin
        mode_next   = lxr_pkg::MODE_DICE;
        tstart_next = pos;
      end else if (is_dig) begin
        mode_next   = lxr_pkg::MODE_INT;
        tstart_next = pos;
        whole_next  = {28'b0, dval};
        frac_next   = '0;
        fcount_next = '0;
        sat_next    = 1'b0;
      end else if (is_let) begin
        mode_next   = lxr_pkg::MODE_ID;
        tstart_next = pos;
      end else if (is_blank) begin
        ent.has_b = 1'b0;
      end else if (char_in == lxr_pkg::CH_NUL) begin
        ent.has_b      = 1'b1;
        ent.tok_b.kind = lxr_pkg::KIND_EOI;
      end else begin
        ent.has_b      = 1'b1;
        ent.tok_b.kind = lxr_pkg::KIND_ERR;
        ent.tok_b.ch   = char_in;
        ent.tok_b.len  = 12'd1;
      end
    end

    if (char_in == lxr_pkg::CH_NUL) begin
      mode_next   = lxr_pkg::MODE_START;
      pos_next    = '0;
      tstart_next = '0;
      whole_next  = '0;
      frac_next   = '0;
      fcount_next = '0;
      sat_next    = 1'b0;
    end else begin
      pos_next = (pos < lxr_pkg::POS_MAX) ? pos + 12'd1 : lxr_pkg::POS_MAX;
    end
  end

  assign push       = accept && (ent.has_a || ent.has_b);
  assign push_entry = ent;

endmodule
`default_nettype wire

[sv/lxr_queue.sv]
// Short register queue of token entries between the lexer front and back.
// Depends on lxr_pkg.
`default_nettype none
module lxr_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lxr_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output lxr_pkg::entry_t      head
);

  lxr_pkg::entry_t slots [lxr_pkg::QUEUE_DEPTH];
  logic [lxr_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [lxr_pkg::QPTR_W:0]   count;
  logic                       do_pop;

  assign full       = (count == (lxr_pkg::QPTR_W + 1)'(lxr_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/lxr_back.sv]
// Back end of the lexer: sends the one or two tokens of each queue entry as output beats.
// Depends on lxr_pkg.
`default_nettype none
module lxr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire lxr_pkg::entry_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output lxr_pkg::token_t      tok,
  output logic                 last
);

  logic phase, phase_next;
  logic sel_b;
  logic beat;

  assign sel_b     = phase || !head.has_a;
  assign tok       = sel_b ? head.tok_b : head.tok_a;
  assign last      = sel_b || !head.has_b;
  assign out_valid = head_valid;
  assign beat      = out_valid && out_ready;
  assign pop       = beat && last;

  always_comb begin
    phase_next = phase;
    if (beat) begin
      phase_next = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else begin
      phase <= phase_next;
    end
  end

endmodule
`default_nettype wire

[sv/expression_token_lexer.sv]
// A token is offered from the queue slot registers once its byte has been accepted.
// Throughput: one byte per cycle unless the queue is full. A byte that closes a token
// and is an operator, end marker or bad byte gives two output beats, and the output
// side then sets the rate. Reset clears the lexer mode, position, accumulators, queue
// and output phase. Top level of the expression token lexer; instantiates lxr_front,
// lxr_queue, lxr_back. Depends on lxr_pkg.
`default_nettype none
module expression_token_lexer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       token_kind,
  output logic [7:0]       token_char,
  output logic [11:0]      start_pos,
  output logic [11:0]      token_length,
  output logic [31:0]      whole_value,
  output logic [31:0]      frac_value,
  output logic [11:0]      frac_digits,
  output logic             value_saturated,
  output logic             last_of_run
);

  logic            queue_full;
  logic            push;
  lxr_pkg::entry_t push_entry;
  logic            pop;
  logic            head_valid;
  lxr_pkg::entry_t head;
  lxr_pkg::token_t tok;

  lxr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lxr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lxr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tok        (tok),
    .last       (last_of_run)
  );

  assign token_kind      = tok.kind;
  assign token_char      = tok.ch;
  assign start_pos       = tok.start;
  assign token_length    = tok.len;
  assign whole_value     = tok.whole;
  assign frac_value      = tok.frac;
  assign frac_digits     = tok.digits;
  assign value_saturated = tok.sat;

  a_first_not_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |->
      (token_kind != lxr_pkg::KIND_EOI) && (token_kind != lxr_pkg::KIND_ERR))
    else $error("end or error token offered before the last beat of its byte");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("second token of a byte was lost");

  a_eoi_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == lxr_pkg::KIND_EOI |->
      token_length == 12'd0 && whole_value == 32'd0)
    else $error("end-of-input token carries length or value");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while no token is waiting");

endmodule
`default_nettype wire
